FILE: design/dtjdn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtjdn_pkg: shared constants and tables for the date to day number unit
// month tables, date keys and the fixed-point reciprocal for division by 100
// ----------------------------------------------------------------------------
package dtjdn_pkg;

	// date key = year * 512 + month * 32 + day, i.e. {year, month, day}
	localparam int KEY_FIRST    = -4712 * 512 + 1 * 32 + 2;
	localparam int KEY_GAP_LO   = 1582 * 512 + 10 * 32 + 5;
	localparam int KEY_GAP_HI   = 1582 * 512 + 10 * 32 + 14;
	localparam int KEY_GREG     = 1582 * 512 + 10 * 32 + 15;
	localparam int YEAR_GREG    = 1582;

	// floor(x / 100) = (x * 5243) >> 19, exact for x below 43690
	localparam logic [12:0] RECIP100   = 13'd5243;
	localparam int          RECIP_SHFT = 19;

	localparam logic [10:0] DAYS_4YR   = 11'd1461;
	localparam logic [12:0] YEAR_BIAS  = 13'd4716;
	localparam logic [10:0] DAY_BIAS   = 11'd1524;

	localparam logic [3:0] MON_JAN = 4'd1;
	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_DEC = 4'd12;
	localparam logic [3:0] MON_WRAP = 4'd12;

	// days in a month, common year
	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// days before the first of a month, common year
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] s;
		case (m)
			4'd1:  s = 9'd0;
			4'd2:  s = 9'd31;
			4'd3:  s = 9'd59;
			4'd4:  s = 9'd90;
			4'd5:  s = 9'd120;
			4'd6:  s = 9'd151;
			4'd7:  s = 9'd181;
			4'd8:  s = 9'd212;
			4'd9:  s = 9'd243;
			4'd10: s = 9'd273;
			4'd11: s = 9'd304;
			4'd12: s = 9'd334;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	// floor(30.6001 * (jm + 1)) for the shifted month 3..14
	function automatic logic [8:0] month_days(input logic [3:0] jm);
		logic [8:0] v;
		case (jm)
			4'd3:  v = 9'd122;
			4'd4:  v = 9'd153;
			4'd5:  v = 9'd183;
			4'd6:  v = 9'd214;
			4'd7:  v = 9'd244;
			4'd8:  v = 9'd275;
			4'd9:  v = 9'd306;
			4'd10: v = 9'd336;
			4'd11: v = 9'd367;
			4'd12: v = 9'd397;
			4'd13: v = 9'd428;
			4'd14: v = 9'd459;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/date_to_julian_day_number_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_to_julian_day_number_unit: calendar date to chronological day number
// converts year, month and day into the day number, weekday, day of year,
// leap flag and a validity flag
// ----------------------------------------------------------------------------
// A four-stage pipeline that takes one date item per clock while the output
// side does not stall and returns one result item per date, registered in
// stage 4. Dates before 15 October 1582 follow the Julian calendar, later
// ones the Gregorian calendar; the leap rule switches at year 1582. A date is
// flagged invalid when the month is outside 1..12, the day is outside the
// month, the date lies before 2 January of year -4712, or it falls on
// 5..14 October 1582; day_number, weekday and year_day then read 0, while leap
// is always given. Stage 1 forms the date keys and the reciprocal products for
// the divisions by 100, stage 2 the leap rule, the checks and the 1461-day
// product, stage 3 the day number sum, stage 4 the weekday by a base-8 digit
// sum mod 7. Each stage holds its item while the stage after it is full and
// stalled, so a bubble is filled even while a result waits to be taken.
// ----------------------------------------------------------------------------
module date_to_julian_day_number_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [14:0] year,
	input  logic        [3:0]  month,
	input  logic        [4:0]  day,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [22:0] day_number,
	output logic        [2:0]  weekday,
	output logic        [8:0]  year_day,
	output logic               leap,
	output logic               valid_res
);
	import dtjdn_pkg::*;

	// stage valid bits and per-stage advance
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// ---------------- stage 1: keys, shifted year/month, reciprocal products
	logic signed [23:0] key_c;
	logic signed [15:0] jy_c;
	logic        [3:0]  jm_c;
	logic signed [24:0] jkey_c;
	logic               early_c;

	assign early_c = (month <= MON_FEB);
	assign key_c   = $signed({year, month, day});
	// january and february count as months 13 and 14 of the year before
	assign jy_c    = early_c ? (16'(year) - 16'sd1) : 16'(year);
	assign jm_c    = early_c ? (month + MON_WRAP) : month;
	assign jkey_c  = $signed({jy_c, jm_c, day});

	logic signed [14:0] y_s1;
	logic        [3:0]  m_s1;
	logic        [4:0]  d_s1;
	logic signed [15:0] jy_s1;
	logic        [3:0]  jm_s1;
	logic        [26:0] py_s1;
	logic        [26:0] pjy_s1;
	logic               mok_s1;
	logic               kbad_s1;
	logic               greg_s1;
	logic               ge_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			y_s1    <= year;
			m_s1    <= month;
			d_s1    <= day;
			jy_s1   <= jy_c;
			jm_s1   <= jm_c;
			// only used when the year is positive, so the low 14 bits suffice
			py_s1   <= 27'(year[13:0]) * 27'(RECIP100);
			pjy_s1  <= 27'(jy_c[13:0]) * 27'(RECIP100);
			mok_s1  <= (month >= MON_JAN) && (month <= MON_DEC);
			kbad_s1 <= (key_c < KEY_FIRST) || ((key_c >= KEY_GAP_LO) && (key_c <= KEY_GAP_HI));
			greg_s1 <= (jkey_c >= KEY_GREG);
			ge_s1   <= (year >= 15'(YEAR_GREG));
		end
	end

	// ---------------- stage 2: leap rule, checks, century term, 1461-day product
	logic [7:0]  q100_c;
	logic [13:0] r100_c;
	logic        div4_c;
	logic        leap_c;
	logic [4:0]  len_c;
	logic        ok_c;
	logic [7:0]  cent_c;
	logic [8:0]  b_c;
	logic [14:0] n_c;
	logic [8:0]  yd_c;

	assign q100_c = py_s1[RECIP_SHFT +: 8];
	assign r100_c = y_s1[13:0] - 14'(14'(q100_c) * 14'd100);
	assign div4_c = (y_s1[1:0] == 2'd0);
	assign leap_c = ge_s1 ? ((div4_c && (r100_c != 14'd0)) ||
	                         ((r100_c == 14'd0) && (q100_c[1:0] == 2'd0)))
	                      : div4_c;
	assign len_c  = month_len(m_s1) + 5'((m_s1 == MON_FEB) && leap_c);
	assign ok_c   = mok_s1 && !kbad_s1 && (d_s1 != 5'd0) && (d_s1 <= len_c);

	// gregorian correction 2 - a + a/4, a = century of the shifted year
	assign cent_c = pjy_s1[RECIP_SHFT +: 8];
	assign b_c    = greg_s1 ? (9'd2 + 9'(cent_c[7:2]) - 9'(cent_c)) : 9'd0;
	assign n_c    = 15'(jy_s1 + $signed({3'd0, YEAR_BIAS}));
	assign yd_c   = month_start(m_s1) + 9'(leap_c && (m_s1 > MON_FEB)) + 9'(d_s1);

	logic               ok_s2;
	logic               leap_s2;
	logic        [25:0] t1_s2;
	logic        [8:0]  t2_s2;
	logic        [4:0]  d_s2;
	logic signed [8:0]  b_s2;
	logic        [8:0]  yd_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			ok_s2   <= ok_c;
			leap_s2 <= leap_c;
			t1_s2   <= 26'(n_c) * 26'(DAYS_4YR);
			t2_s2   <= month_days(jm_s1);
			d_s2    <= d_s1;
			b_s2    <= $signed(b_c);
			yd_s2   <= yd_c;
		end
	end

	// ---------------- stage 3: day number sum
	logic [24:0] jdn_c;

	assign jdn_c = 25'(t1_s2[25:2]) + 25'(t2_s2) + 25'(d_s2) + 25'(b_s2) - 25'(DAY_BIAS);

	logic        ok_s3;
	logic        leap_s3;
	logic [22:0] jdn_s3;
	logic [8:0]  yd_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			ok_s3   <= ok_s2;
			leap_s3 <= leap_s2;
			jdn_s3  <= jdn_c[22:0];
			yd_s3   <= yd_s2;
		end
	end

	// ---------------- stage 4: weekday, since 8 = 1 mod 7 sum the octal digits
	logic [5:0] dsum_c;
	logic [3:0] fold_c;
	logic [2:0] mod7_c;

	always_comb begin
		dsum_c = 6'(jdn_s3[22:21]);
		for (int i = 0; i < 7; i++) begin
			dsum_c = dsum_c + 6'(jdn_s3[3*i +: 3]);
		end
	end

	assign fold_c = 4'(dsum_c[5:3]) + 4'(dsum_c[2:0]);
	assign mod7_c = (fold_c >= 4'd7) ? 3'(fold_c - 4'd7) : fold_c[2:0];

	always_ff @(posedge clk) begin
		if (en4) begin
			day_number <= ok_s3 ? jdn_s3 : 23'd0;
			weekday    <= ok_s3 ? (mod7_c + 3'd1) : 3'd0;
			year_day   <= ok_s3 ? yd_s3 : 9'd0;
			leap       <= leap_s3;
			valid_res  <= ok_s3;
		end
	end

endmodule
